// File: sv/ocfp_pkg.sv
// Shared types and constants for the offer string parser.
`default_nettype none

package ocfp_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int OUT_W          = 16;

	localparam logic [2:0] NUM_FIELDS = 3'd7;

	// Field positions whose values are kept
	localparam logic [2:0] FLD_X_DPI  = 3'd0;
	localparam logic [2:0] FLD_Y_DPI  = 3'd1;
	localparam logic [2:0] FLD_WIDTH  = 3'd4;
	localparam logic [2:0] FLD_HEIGHT = 3'd6;

	localparam logic [7:0] SEPARATOR  = 8'h2C;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic             offer_valid;
		logic [OUT_W-1:0] x_dpi;
		logic [OUT_W-1:0] y_dpi;
		logic [OUT_W-1:0] max_width;
		logic [OUT_W-1:0] max_height;
	} offer_item_t;

	typedef struct packed {
		logic       take;
		text_item_t item;
	} ocfp_ctl_t;

endpackage

`default_nettype wire

// File: sv/ocfp_core.sv
// Parse state and per-character update of the offer string parser.
`default_nettype none

module ocfp_core import ocfp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ocfp_ctl_t   ctl,
	output offer_item_t      res
);

	localparam int PROD_W = VALUE_BITS + 4;
	localparam int EXT_W  = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;

	logic [2:0]            field_index_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  has_digit_q;
	logic                  malformed_q;
	logic [OUT_W-1:0]      held_x_q;
	logic [OUT_W-1:0]      held_y_q;
	logic [OUT_W-1:0]      held_w_q;
	logic [OUT_W-1:0]      held_h_q;

	logic                  is_digit;
	logic                  is_sep;
	logic                  all_closed;
	logic                  ok;
	logic [3:0]            digit;
	logic [PROD_W-1:0]     acc_w;
	logic [PROD_W-1:0]     prod;
	logic [VALUE_BITS-1:0] acc_next;
	logic [EXT_W-1:0]      acc_ext;
	logic [OUT_W-1:0]      acc_lo;

	assign is_digit   = (ctl.item.character >= DIGIT_ZERO) &&
		(ctl.item.character <= DIGIT_NINE);
	assign is_sep     = (ctl.item.character == SEPARATOR);
	assign all_closed = (field_index_q >= NUM_FIELDS);
	assign ok         = !malformed_q && (field_index_q == NUM_FIELDS);

	assign digit    = 4'(ctl.item.character - DIGIT_ZERO);
	assign acc_w    = PROD_W'(acc_q);
	// times ten as 8x + 2x
	assign prod     = (acc_w << 3) + (acc_w << 1) + PROD_W'(digit);
	assign acc_next = (|prod[PROD_W-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
		: prod[VALUE_BITS-1:0];

	assign acc_ext = EXT_W'(acc_q);
	assign acc_lo  = acc_ext[OUT_W-1:0];

	always_comb begin
		res.offer_valid = ok;
		res.x_dpi       = ok ? held_x_q : '0;
		res.y_dpi       = ok ? held_y_q : '0;
		res.max_width   = ok ? held_w_q : '0;
		res.max_height  = ok ? held_h_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= '0;
			acc_q         <= '0;
			has_digit_q   <= 1'b0;
			malformed_q   <= 1'b0;
			held_x_q      <= '0;
			held_y_q      <= '0;
			held_w_q      <= '0;
			held_h_q      <= '0;
		end else if (ctl.take) begin
			if (ctl.item.end_of_text) begin
				field_index_q <= '0;
				acc_q         <= '0;
				has_digit_q   <= 1'b0;
				malformed_q   <= 1'b0;
				held_x_q      <= '0;
				held_y_q      <= '0;
				held_w_q      <= '0;
				held_h_q      <= '0;
			end else if (!malformed_q) begin
				if (is_digit) begin
					if (all_closed) begin
						malformed_q <= 1'b1;
					end else begin
						acc_q       <= acc_next;
						has_digit_q <= 1'b1;
					end
				end else if (is_sep) begin
					if (all_closed || !has_digit_q) begin
						malformed_q <= 1'b1;
					end else begin
						case (field_index_q)
							FLD_X_DPI:  held_x_q <= acc_lo;
							FLD_Y_DPI:  held_y_q <= acc_lo;
							FLD_WIDTH:  held_w_q <= acc_lo;
							FLD_HEIGHT: held_h_q <= acc_lo;
							default: ;
						endcase
						field_index_q <= field_index_q + 3'd1;
						acc_q         <= '0;
						has_digit_q   <= 1'b0;
					end
				end else begin
					malformed_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_digit_open_field: assert property (@(posedge clk) disable iff (!arst_n)
		has_digit_q |-> (field_index_q < NUM_FIELDS))
		else $error("digit flag set with all fields closed");

	a_empty_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!has_digit_q |-> (acc_q == '0))
		else $error("accumulator not clear for an empty field");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.take && ctl.item.end_of_text) |=>
		(field_index_q == '0 && !malformed_q && !has_digit_q))
		else $error("parser did not restart after end of text");
`endif

endmodule

`default_nettype wire

// File: sv/offer_csv_field_parser.sv
// Top level of the offer string parser: input register, parser core, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  text     | text_valid / text_stall    | text_item_t: character, end_of_text
//  result   | result_valid / result_stall| offer_item_t: offer_valid, x_dpi, y_dpi,
//           |                            |   max_width, max_height
//
// One character per cycle; a request enters the input register and is parsed from there,
// and parsing an end-of-text request also loads the result register and raises result_valid.
// Only an end-of-text request waits on a full, stalled result register; characters flow on.
// Reset (asynchronous) empties both registers and clears the parse state.
`default_nettype none

module offer_csv_field_parser import ocfp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire text_item_t  text,
	output logic             result_valid,
	input  wire logic        result_stall,
	output offer_item_t      result
);

	logic        text_vld_s1;
	text_item_t  text_s1;
	logic        result_vld_q;
	offer_item_t result_q;
	logic        advance;
	ocfp_ctl_t   core_ctl;
	offer_item_t core_res;

	// an end-of-text request needs a free result slot
	assign advance    = text_vld_s1 &&
		(!text_s1.end_of_text || !result_vld_q || !result_stall);
	assign text_stall = text_vld_s1 && !advance;

	assign core_ctl.take = advance;
	assign core_ctl.item = text_s1;

	ocfp_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (core_ctl),
		.res   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_vld_s1  <= 1'b0;
			result_vld_q <= 1'b0;
		end else begin
			if (!text_stall) begin
				text_vld_s1 <= text_valid;
			end
			if (advance && text_s1.end_of_text) begin
				result_vld_q <= 1'b1;
			end else if (!result_stall) begin
				result_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			text_s1 <= text;
		end
		if (advance && text_s1.end_of_text) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_stall_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> (text_vld_s1 && text_s1.end_of_text && result_vld_q))
		else $error("input stalled without a pending end of text");

	a_stalled_request_kept: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |=> (text_vld_s1 && text_s1.end_of_text))
		else $error("stalled end-of-text request lost");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.offer_valid) |->
		(result.x_dpi == '0 && result.y_dpi == '0 &&
		result.max_width == '0 && result.max_height == '0))
		else $error("invalid offer carries non-zero fields");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the offer string parser: random and directed offer strings.
`timescale 1ns / 1ps

module testbench import ocfp_pkg::*;;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int TARGET_REQS  = 1450;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PCT     = 26;

	typedef enum int {
		FLAW_NONE, FLAW_EMPTY, FLAW_FOREIGN, FLAW_TRAILING,
		FLAW_SHORT, FLAW_UNCLOSED, FLAW_NOISE
	} flaw_e;

	class offer_scoreboard;
		offer_item_t      expected_offers[$];
		logic [2:0]       fields_closed;
		int unsigned      field_value;
		bit               field_has_digit;
		bit               string_broken;
		logic [OUT_W-1:0] kept_x_dpi, kept_y_dpi, kept_width, kept_height;
		int               errors, checked, good_offers, bad_offers, requests;

		function new();
			errors = 0;
			checked = 0;
			good_offers = 0;
			bad_offers = 0;
			requests = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			fields_closed   = '0;
			field_value     = 0;
			field_has_digit = 0;
			string_broken   = 0;
			kept_x_dpi      = '0;
			kept_y_dpi      = '0;
			kept_width      = '0;
			kept_height     = '0;
		endfunction

		function int pending();
			return expected_offers.size();
		endfunction

		function void note_request(text_item_t req);
			offer_item_t want;
			int unsigned value_max;
			value_max = (1 << VALUE_BITS_DEF) - 1;
			requests++;
			if (req.end_of_text) begin
				want = '0;
				if (!string_broken && fields_closed == NUM_FIELDS) begin
					want.offer_valid = 1'b1;
					want.x_dpi       = kept_x_dpi;
					want.y_dpi       = kept_y_dpi;
					want.max_width   = kept_width;
					want.max_height  = kept_height;
				end
				expected_offers = {expected_offers, want};
				clear_parse();
				return;
			end
			// once broken, everything up to the end marker is ignored
			if (string_broken)
				return;
			if (req.character >= DIGIT_ZERO && req.character <= DIGIT_NINE) begin
				if (fields_closed >= NUM_FIELDS) begin
					string_broken = 1;
				end else begin
					field_value = field_value * 10 + (req.character - DIGIT_ZERO);
					if (field_value > value_max)
						field_value = value_max;
					field_has_digit = 1;
				end
			end else if (req.character == SEPARATOR) begin
				if (fields_closed >= NUM_FIELDS || !field_has_digit) begin
					string_broken = 1;
				end else begin
					case (fields_closed)
						FLD_X_DPI:  kept_x_dpi  = field_value[OUT_W-1:0];
						FLD_Y_DPI:  kept_y_dpi  = field_value[OUT_W-1:0];
						FLD_WIDTH:  kept_width  = field_value[OUT_W-1:0];
						FLD_HEIGHT: kept_height = field_value[OUT_W-1:0];
						default: ;
					endcase
					fields_closed   = fields_closed + 1'b1;
					field_value     = 0;
					field_has_digit = 0;
				end
			end else begin
				string_broken = 1;
			end
		endfunction

		function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(offer_item_t got);
			offer_item_t want;
			if (expected_offers.size() == 0) begin
				$display("%0t: result with none expected: valid %0b x %0d y %0d w %0d h %0d",
					$time, got.offer_valid, got.x_dpi, got.y_dpi, got.max_width,
					got.max_height);
				errors++;
				return;
			end
			want = expected_offers.pop_front();
			checked++;
			if (want.offer_valid)
				good_offers++;
			else
				bad_offers++;
			compare_field("offer_valid", OUT_W'(want.offer_valid), OUT_W'(got.offer_valid));
			compare_field("x_dpi", want.x_dpi, got.x_dpi);
			compare_field("y_dpi", want.y_dpi, got.y_dpi);
			compare_field("max_width", want.max_width, got.max_width);
			compare_field("max_height", want.max_height, got.max_height);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_stall;
	text_item_t  text;
	logic        result_valid;
	logic        result_stall;
	offer_item_t result;

	offer_scoreboard sb = new();
	text_item_t      offer_text[$];
	int              idle_pct = IDLE_PCT;
	int              strings_sent = 0;
	int              stalled_cycles = 0;
	int              hold_left = 0;
	bit              hold_done = 0;

	offer_csv_field_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text         (text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic push_char(input logic [7:0] c);
		text_item_t t;
		t.character   = c;
		t.end_of_text = 1'b0;
		offer_text = {offer_text, t};
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	task automatic push_end();
		text_item_t t;
		t.character   = 8'($urandom_range(0, 255));
		t.end_of_text = 1'b1;
		offer_text = {offer_text, t};
	endtask

	task automatic push_number();
		int unsigned v;
		string s;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 65535;
			2: v = 65536;
			3: v = $urandom_range(60000, 999999);
			4: v = $urandom_range(0, 9);
			default: v = $urandom_range(0, 2000);
		endcase
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 7) == 0)
			s = {"00", s};
		push_text(s);
	endtask

	task automatic push_foreign();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= DIGIT_ZERO && b <= DIGIT_NINE) || b == SEPARATOR);
		push_char(b);
	endtask

	// one offer string, mostly well formed, otherwise with a single kind of flaw
	task automatic make_offer();
		flaw_e flaw;
		int    n_fields;
		int    spot;
		offer_text.delete();
		flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE
			: flaw_e'($urandom_range(FLAW_EMPTY, FLAW_NOISE));
		spot = $urandom_range(0, 6);
		if (flaw == FLAW_NOISE) begin
			repeat ($urandom_range(1, 20)) begin
				case ($urandom_range(0, 9))
					0, 1, 2: push_char(DIGIT_ZERO + 8'($urandom_range(0, 9)));
					3, 4:    push_char(SEPARATOR);
					default: push_char(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			n_fields = (flaw == FLAW_SHORT) ? $urandom_range(0, 6)
				: (flaw == FLAW_UNCLOSED) ? 6 : 7;
			for (int f = 0; f < n_fields; f++) begin
				if (!(flaw == FLAW_EMPTY && f == spot))
					push_number();
				if (flaw == FLAW_FOREIGN && f == spot)
					push_foreign();
				push_char(SEPARATOR);
			end
			if (flaw == FLAW_UNCLOSED)
				push_number();
			if (flaw == FLAW_TRAILING) begin
				if ($urandom_range(0, 1))
					push_char(DIGIT_ZERO + 8'($urandom_range(0, 9)));
				else
					push_char(SEPARATOR);
				repeat ($urandom_range(0, 3))
					push_char(8'($urandom_range(0, 255)));
			end
		end
		push_end();
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input text_item_t req);
		while ($urandom_range(0, 99) < idle_pct) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text       <= req;
		do
			@(posedge clk);
		while (text_stall);
		sb.note_request(req);
		@(negedge clk);
	endtask

	task automatic send_offer();
		foreach (offer_text[i])
			send_request(offer_text[i]);
		strings_sent++;
	endtask

	// receiver: random stalls, plus one long hold-off so the input backs up
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				sb.check_result(result);
			@(negedge clk);
			if (!hold_done && sb.checked >= 10) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(0, 99) < idle_pct);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
			if (text_valid && text_stall)
				stalled_cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		text_valid = 1'b0;
		text       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: bare end marker, empty field, characters either side of the digits,
		// then a well-formed string with a saturating first field
		offer_text.delete();
		push_end();
		push_text(",");
		push_end();
		push_char(DIGIT_ZERO - 8'd1);
		push_char(DIGIT_NINE);
		push_char(DIGIT_NINE + 8'd1);
		push_end();
		push_text("99999,0,0,0,0,0,0,");
		push_end();
		foreach (offer_text[i])
			send_request(offer_text[i]);

		while (sb.requests < TARGET_REQS) begin
			// a stretch with no idling on either side
			idle_pct = (strings_sent >= 25 && strings_sent < 35) ? 0 : IDLE_PCT;
			make_offer();
			send_offer();
		end
		idle_pct = IDLE_PCT;
		text_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests in %0d offer strings: %0d offers accepted, %0d rejected",
			sb.requests, strings_sent, sb.good_offers, sb.bad_offers);
		$display("input held back for %0d cycles while results were blocked", stalled_cycles);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
